// ----- hdl/tfst_pkg.sv -----
`timescale 1ns / 1ps

package tfst_pkg;

  // Fixed field widths of the command and result words
  localparam int TASK_ID_W     = 4;
  localparam int DUR_PORT_W    = 8;
  localparam int CODE_W        = 3;
  localparam int WAIT_MAX_W    = 11;
  localparam int WAIT_MAX_LIMIT = 2047;

  // Command opcodes
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_RUN      = 1'b1;

  // Result codes
  typedef enum logic [CODE_W-1:0] {
    RC_SCHEDULED  = 3'd0,
    RC_NOT_IDLE   = 3'd1,
    RC_FULL       = 3'd2,
    RC_EMPTY      = 3'd3,
    RC_DISPATCHED = 3'd4,
    RC_BAD_ID     = 3'd5
  } tfst_rc_e;

  // Per-task status
  typedef enum logic [1:0] {
    TS_IDLE   = 2'd0,
    TS_QUEUED = 2'd1,
    TS_DONE   = 2'd2
  } tfst_status_e;

  // Controller states
  typedef enum logic {
    FSM_IDLE = 1'b0,
    FSM_EXEC = 1'b1
  } tfst_fsm_e;

  // Status table access from the controller
  typedef struct packed {
    logic                 rd_en;
    logic [TASK_ID_W-1:0] rd_id;
    logic                 wr_en;
    logic [TASK_ID_W-1:0] wr_id;
    tfst_status_e         wr_status;
  } tfst_stat_req_t;

endpackage

// ----- hdl/tfst_slot_ram.sv -----
`timescale 1ns / 1ps

module tfst_slot_ram #(
  parameter int DEPTH = 5,
  parameter int WIDTH = 12,
  parameter int AW    = 3
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/tfst_status_table.sv -----
`timescale 1ns / 1ps

module tfst_status_table #(
  parameter int NUM_TASKS = 10
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tfst_pkg::tfst_stat_req_t req_i,
  output tfst_pkg::tfst_status_e rd_status_o
);

  localparam int AW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int CmpW = tfst_pkg::TASK_ID_W + 1;

  tfst_pkg::tfst_status_e mem [NUM_TASKS];
  logic [NUM_TASKS-1:0]   valid_q;
  tfst_pkg::tfst_status_e rd_status_q;

  logic [AW-1:0] rd_idx;
  logic [AW-1:0] wr_idx;
  logic          rd_in_range;
  logic          wr_in_range;

  assign rd_idx      = req_i.rd_id[AW-1:0];
  assign wr_idx      = req_i.wr_id[AW-1:0];
  assign rd_in_range = CmpW'(req_i.rd_id) < CmpW'(NUM_TASKS);
  assign wr_in_range = CmpW'(req_i.wr_id) < CmpW'(NUM_TASKS);

  // Status storage
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en && wr_in_range) begin
      mem[wr_idx] <= req_i.wr_status;
    end
  end

  // Valid bits: an entry never written reads as idle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (req_i.wr_en && wr_in_range) begin
      valid_q[wr_idx] <= 1'b1;
    end
  end

  // Registered read
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      if (rd_in_range && valid_q[rd_idx]) begin
        rd_status_q <= mem[rd_idx];
      end else begin
        rd_status_q <= tfst_pkg::TS_IDLE;
      end
    end
  end

  assign rd_status_o = rd_status_q;

endmodule

// ----- hdl/task_fifo_with_status_table.sv -----
`timescale 1ns / 1ps

// Task queue with per-task status. A word is taken when start_i is high and
// busy_o is low. In the accept cycle the status table and the slot memory
// are read (both reads are registered), and in the following cycle, with
// busy_o high, the controller decides the outcome and writes back the slot,
// pointers, running duration sum and task status. The outcome is registered
// onto the result ports with done_o high for one cycle; the receiver cannot
// stall it, and a new word may be accepted in that same cycle. No new word is
// taken while busy_o is high. The status table resets to idle at once through
// per-entry valid bits; no clearing pass is needed.
module task_fifo_with_status_table #(
  parameter int QUEUE_DEPTH   = 5,
  parameter int NUM_TASKS     = 10,
  parameter int DURATION_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic                                op_i,
  input  logic [tfst_pkg::TASK_ID_W-1:0]      task_id_i,
  input  logic [tfst_pkg::DUR_PORT_W-1:0]     task_duration_i,
  output logic                                done_o,
  output logic [tfst_pkg::CODE_W-1:0]         result_code_o,
  output logic [tfst_pkg::TASK_ID_W-1:0]      run_id_o,
  output logic [tfst_pkg::DUR_PORT_W-1:0]     run_duration_o,
  output logic [tfst_pkg::DUR_PORT_W-1:0]     wait_min_o,
  output logic [tfst_pkg::WAIT_MAX_W-1:0]     wait_max_o
);

  localparam int IdW   = tfst_pkg::TASK_ID_W;
  localparam int DpW   = tfst_pkg::DUR_PORT_W;
  localparam int WmW   = tfst_pkg::WAIT_MAX_W;
  localparam int PtrW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int OccW  = $clog2(QUEUE_DEPTH + 1);
  localparam int TotW  = DURATION_BITS + $clog2(QUEUE_DEPTH);
  localparam int SlotW = IdW + DURATION_BITS;
  localparam int CmpW  = IdW + 1;

  tfst_pkg::tfst_fsm_e state_q, state_d;

  // Latched command word
  logic                     op_q;
  logic [IdW-1:0]           id_q;
  logic [DURATION_BITS-1:0] dur_q;

  // Queue bookkeeping
  logic [PtrW-1:0] head_q, head_d;
  logic [PtrW-1:0] tail_q, tail_d;
  logic [OccW-1:0] occ_q, occ_d;
  logic [TotW-1:0] total_q, total_d;

  // Result register
  logic                 done_q, done_d;
  tfst_pkg::tfst_rc_e   code_q, code_d;
  logic [IdW-1:0]       run_id_q, run_id_d;
  logic [DpW-1:0]       run_dur_q, run_dur_d;
  logic [DpW-1:0]       wmin_q, wmin_d;
  logic [WmW-1:0]       wmax_q, wmax_d;

  logic accept;
  logic exec;

  // Memory interfaces
  logic                     slot_we;
  logic [SlotW-1:0]         slot_wdata;
  logic [SlotW-1:0]         slot_rdata;
  logic [IdW-1:0]           slot_id;
  logic [DURATION_BITS-1:0] slot_dur;
  tfst_pkg::tfst_stat_req_t stat_req;
  tfst_pkg::tfst_status_e   stat_rd;

  // Width adaptation between the 8-bit ports and DURATION_BITS storage
  logic [DURATION_BITS+DpW-1:0] dur_in_ext;
  logic [DURATION_BITS+DpW-1:0] slot_dur_ext;
  logic [TotW+WmW-1:0]          total_ext;
  logic [DpW-1:0]               slot_dur_port;
  logic [WmW-1:0]               total_sat;

  assign dur_in_ext    = {{DURATION_BITS{1'b0}}, task_duration_i};
  assign slot_dur_ext  = {{DpW{1'b0}}, slot_dur};
  assign slot_dur_port = slot_dur_ext[DpW-1:0];
  assign total_ext     = {{WmW{1'b0}}, total_q};
  assign total_sat     = (total_ext > (TotW+WmW)'(tfst_pkg::WAIT_MAX_LIMIT))
                         ? WmW'(tfst_pkg::WAIT_MAX_LIMIT) : total_ext[WmW-1:0];

  assign {slot_id, slot_dur} = slot_rdata;

  assign accept = start_i && !busy_o;
  assign exec   = (state_q == tfst_pkg::FSM_EXEC);

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tfst_pkg::FSM_IDLE: begin
        if (start_i) state_d = tfst_pkg::FSM_EXEC;
      end
      tfst_pkg::FSM_EXEC: state_d = tfst_pkg::FSM_IDLE;
      default:            state_d = tfst_pkg::FSM_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    case (state_q)
      tfst_pkg::FSM_EXEC: busy_o = 1'b1;
      default:            busy_o = 1'b0;
    endcase
  end

  // Decide and write back
  always_comb begin
    head_d     = head_q;
    tail_d     = tail_q;
    occ_d      = occ_q;
    total_d    = total_q;
    done_d     = exec;
    code_d     = code_q;
    run_id_d   = run_id_q;
    run_dur_d  = run_dur_q;
    wmin_d     = wmin_q;
    wmax_d     = wmax_q;
    slot_we    = 1'b0;
    slot_wdata = {id_q, dur_q};

    stat_req.rd_en     = accept;
    stat_req.rd_id     = task_id_i;
    stat_req.wr_en     = 1'b0;
    stat_req.wr_id     = id_q;
    stat_req.wr_status = tfst_pkg::TS_QUEUED;

    if (exec) begin
      run_id_d  = '0;
      run_dur_d = '0;
      wmin_d    = '0;
      wmax_d    = '0;
      if (op_q == tfst_pkg::OP_SCHEDULE) begin
        if (CmpW'(id_q) >= CmpW'(NUM_TASKS)) begin
          code_d = tfst_pkg::RC_BAD_ID;
        end else if (stat_rd != tfst_pkg::TS_IDLE) begin
          code_d = tfst_pkg::RC_NOT_IDLE;
        end else if (occ_q == OccW'(QUEUE_DEPTH)) begin
          code_d = tfst_pkg::RC_FULL;
          wmin_d = slot_dur_port;
          wmax_d = total_sat;
        end else begin
          code_d         = tfst_pkg::RC_SCHEDULED;
          slot_we        = 1'b1;
          tail_d         = (tail_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : tail_q + PtrW'(1);
          occ_d          = occ_q + OccW'(1);
          total_d        = total_q + TotW'(dur_q);
          stat_req.wr_en = 1'b1;
        end
      end else begin
        if (occ_q == '0) begin
          code_d = tfst_pkg::RC_EMPTY;
        end else begin
          code_d             = tfst_pkg::RC_DISPATCHED;
          run_id_d           = slot_id;
          run_dur_d          = slot_dur_port;
          head_d             = (head_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : head_q + PtrW'(1);
          occ_d              = occ_q - OccW'(1);
          total_d            = total_q - TotW'(slot_dur);
          stat_req.wr_en     = 1'b1;
          stat_req.wr_id     = slot_id;
          stat_req.wr_status = tfst_pkg::TS_DONE;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tfst_pkg::FSM_IDLE;
      head_q  <= '0;
      tail_q  <= '0;
      occ_q   <= '0;
      total_q <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      tail_q  <= tail_d;
      occ_q   <= occ_d;
      total_q <= total_d;
      done_q  <= done_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_i;
      id_q  <= task_id_i;
      dur_q <= dur_in_ext[DURATION_BITS-1:0];
    end
    code_q    <= code_d;
    run_id_q  <= run_id_d;
    run_dur_q <= run_dur_d;
    wmin_q    <= wmin_d;
    wmax_q    <= wmax_d;
  end

  // Head slot is read at accept; head only moves in the execute cycle
  tfst_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .WIDTH (SlotW),
    .AW    (PtrW)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (tail_q),
    .wdata_i (slot_wdata),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (slot_rdata)
  );

  tfst_status_table #(
    .NUM_TASKS (NUM_TASKS)
  ) u_status_table (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (stat_req),
    .rd_status_o (stat_rd)
  );

  assign done_o         = done_q;
  assign result_code_o  = code_q;
  assign run_id_o       = run_id_q;
  assign run_duration_o = run_dur_q;
  assign wait_min_o     = wmin_q;
  assign wait_max_o     = wmax_q;

endmodule

// ----- hdl/tfst_checker.sv -----
`timescale 1ns / 1ps

module tfst_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            start_i,
  input logic                            busy_o,
  input logic                            done_o,
  input logic [tfst_pkg::CODE_W-1:0]     result_code_o,
  input logic [tfst_pkg::TASK_ID_W-1:0]  run_id_o,
  input logic [tfst_pkg::DUR_PORT_W-1:0] run_duration_o,
  input logic [tfst_pkg::DUR_PORT_W-1:0] wait_min_o,
  input logic [tfst_pkg::WAIT_MAX_W-1:0] wait_max_o
);

  // An accepted word raises busy in the cycle after it is taken
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("accepted word did not raise busy");

  // Each accept is followed by a result
  a_accept_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |-> ##2 done_o)
    else $error("result missing after accept");

  // No result without a busy cycle before it
  a_done_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o))
    else $error("result without a word in flight");

  // Dispatch fields are zero unless a task was dispatched
  a_run_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_code_o != tfst_pkg::RC_DISPATCHED)
      |-> (run_id_o == '0 && run_duration_o == '0))
    else $error("dispatch fields set on a non-dispatch result");

  // Wait range is zero unless the queue was full
  a_wait_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_code_o != tfst_pkg::RC_FULL)
      |-> (wait_min_o == '0 && wait_max_o == '0))
    else $error("wait range set on a non-full result");

endmodule

bind task_fifo_with_status_table tfst_checker u_tfst_checker (.*);
